### rtl/core/rcfp_pkg.sv
package rcfp_pkg;

  // Frame layout
  localparam int unsigned CH_COUNT  = 16;
  localparam int unsigned CH_BITS   = 11;
  localparam int unsigned CH_CENTER = 992;
  localparam logic [7:0]  FRAME_LEN = 8'd24;

  // CRC8, MSB first, no final xor
  localparam logic [7:0]  CRC_POLY  = 8'hD5;

  // Register reset values
  localparam logic [7:0]  DEST_RESET = 8'd238;
  localparam logic [7:0]  TYPE_RESET = 8'd22;

  // Register select, taken from address bit 2
  localparam logic        REG_DEST = 1'b0;
  localparam logic        REG_TYPE = 1'b1;

  // Most bytes one channel can cause
  localparam int unsigned BURST_MAX = 4;

  // Packing state carried from one channel to the next
  typedef struct packed {
    logic [3:0] ch_idx;   // next channel within the frame
    logic [6:0] bits;     // leftover packed bits, LSB first
    logic [2:0] nbits;    // number of valid leftover bits
    logic [7:0] crc;      // running CRC over type and payload
  } pack_state_t;

  // Bytes caused by one channel, sent in index order
  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [1:0]                last_idx;
    logic                      eof;      // last byte is the frame CRC
  } burst_t;

  // Fold one byte into the CRC
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### rtl/core/rcfp_scale.sv
module rcfp_scale (
  input  logic [15:0] value,
  output logic [10:0] pos
);
  import rcfp_pkg::*;

  localparam logic [15:0] RECIP_5 = 16'd52429;  // ceil(2^18 / 5)
  localparam logic [9:0]  CENTER  = 10'(CH_CENTER);

  logic        neg;
  logic [15:0] mag;
  logic [17:0] mag4;
  logic [33:0] prod;
  logic [15:0] quot;
  logic [9:0]  quot_sat;

  // Scale the magnitude by 4/5; truncation of the magnitude rounds toward zero
  always_comb begin
    neg      = value[15];
    mag      = neg ? (~value + 16'd1) : value;
    mag4     = {mag, 2'b00};
    prod     = 34'(mag4) * 34'(RECIP_5);
    quot     = prod[33:18];
    // Clamp the offset to 0..center, keeping the position within 0..2*center
    quot_sat = (quot > 16'(CH_CENTER)) ? CENTER : quot[9:0];
    pos      = neg ? (11'(CENTER) - 11'(quot_sat)) : (11'(CENTER) + 11'(quot_sat));
  end

endmodule

### rtl/core/rcfp_pack.sv
module rcfp_pack (
  input  rcfp_pkg::pack_state_t st,
  input  logic [10:0]           pos,
  input  logic [7:0]            dest_address,
  input  logic [7:0]            frame_type,
  input  logic [7:0]            type_crc,
  output rcfp_pkg::burst_t      burst,
  output rcfp_pkg::pack_state_t st_nxt
);
  import rcfp_pkg::*;

  logic        first;
  logic        last_ch;
  logic [6:0]  bits_in;
  logic [2:0]  nbits_in;
  logic [17:0] acc;
  logic [4:0]  total;
  logic        two;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [7:0]  crc_base;
  logic [7:0]  crc1;
  logic [7:0]  crc2;
  logic [1:0]  p0;
  logic [1:0]  pc;

  // Append the channel to the leftover bits
  always_comb begin
    first    = (st.ch_idx == 4'd0);
    last_ch  = (st.ch_idx == 4'(CH_COUNT - 1));
    bits_in  = first ? 7'd0 : st.bits;
    nbits_in = first ? 3'd0 : st.nbits;
    acc      = {11'd0, bits_in} | ({7'd0, pos} << nbits_in);
    total    = {2'd0, nbits_in} + 5'(CH_BITS);
    two      = total[4];
    b0       = acc[7:0];
    b1       = acc[15:8];
  end

  // Run the CRC over the completed bytes
  always_comb begin
    crc_base = first ? type_crc : st.crc;
    crc1     = crc8_byte(crc_base, b0);
    crc2     = two ? crc8_byte(crc1, b1) : crc1;
  end

  // Lay out header, payload and CRC bytes in send order
  always_comb begin
    burst.bytes = '0;
    p0 = first ? 2'd3 : 2'd0;
    if (first) begin
      burst.bytes[0] = dest_address;
      burst.bytes[1] = FRAME_LEN;
      burst.bytes[2] = frame_type;
    end
    burst.bytes[p0] = b0;
    if (two) begin
      burst.bytes[p0 + 2'd1] = b1;
    end
    pc = p0 + 2'd1 + {1'b0, two};
    if (last_ch) begin
      burst.bytes[pc] = crc2;
    end
    burst.last_idx = last_ch ? pc : (p0 + {1'b0, two});
    burst.eof      = last_ch;
  end

  // Advance the packing state; close the frame after the last channel
  always_comb begin
    st_nxt.crc = crc2;
    if (last_ch) begin
      st_nxt.ch_idx = 4'd0;
      st_nxt.bits   = 7'd0;
      st_nxt.nbits  = 3'd0;
    end else begin
      st_nxt.ch_idx = st.ch_idx + 4'd1;
      st_nxt.bits   = two ? {5'd0, acc[17:16]} : acc[14:8];
      st_nxt.nbits  = two ? 3'(total - 5'd16) : 3'(total - 5'd8);
    end
  end

endmodule

### rtl/core/rc_channel_frame_packer.sv
// Channel  Direction  Payload
// in_      slave      tdata[15:0] channel_value (signed)
// out_     master     tdata[7:0] frame_byte, tuser last_of_item, tlast end_of_frame
// cfg_     APB        0x0 dest_address, 0x4 frame_type (8 bits each)
//
// An item passes an input register, a scaling register (4/5 multiply and clamp)
// and a burst register that holds the one to four bytes it causes.
// Bytes leave one per cycle while out_tready is high, so the output byte port
// sets the pace at which items pass.
// Each stage refills in the cycle it empties, so out_tready low stalls back
// to the input only once all three stages hold an item.
// Reset (synchronous, rst_n low) empties the pipeline and restarts the frame.
module rc_channel_frame_packer (
  input  logic        clk,
  input  logic        rst_n,
  // channel_value[15:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // frame_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  // last_of_item[0]
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rcfp_pkg::*;

  logic [7:0]  dest_r;
  logic [7:0]  type_r;
  logic [7:0]  type_crc_r;
  logic        cfg_wr;

  logic        in_v_r;
  logic [15:0] in_data_r;
  logic        val_v_r;
  logic [10:0] val_r;
  logic [10:0] pos;

  pack_state_t st_r;
  pack_state_t st_nxt;
  burst_t      burst;
  burst_t      burst_r;
  logic        bv_r;
  logic [1:0]  idx_r;

  logic        at_last;
  logic        take_last;
  logic        s3_free;
  logic        s2_free;
  logic        s2_adv;
  logic        s1_adv;
  logic        s1_free;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_TYPE) ? {24'd0, type_r} : {24'd0, dest_r};

  // Hold registers; keep the CRC of the type byte alongside it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r     <= DEST_RESET;
      type_r     <= TYPE_RESET;
      type_crc_r <= crc8_byte(8'd0, TYPE_RESET);
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_DEST) begin
        dest_r <= cfg_pwdata[7:0];
      end else begin
        type_r     <= cfg_pwdata[7:0];
        type_crc_r <= crc8_byte(8'd0, cfg_pwdata[7:0]);
      end
    end
  end

  // Pipeline flow control
  always_comb begin
    at_last   = (idx_r == burst_r.last_idx);
    take_last = bv_r & out_tready & at_last;
    s3_free   = ~bv_r | take_last;
    s2_adv    = val_v_r & s3_free;
    s2_free   = ~val_v_r | s3_free;
    s1_adv    = in_v_r & s2_free;
    s1_free   = ~in_v_r | s2_free;
  end

  assign in_tready = s1_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (s1_free) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_tvalid) begin
      in_data_r <= in_tdata;
    end
  end

  rcfp_scale u_scale (
    .value (in_data_r),
    .pos   (pos)
  );

  // Scaled channel register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_v_r <= 1'b0;
    end else if (s2_free) begin
      val_v_r <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      val_r <= pos;
    end
  end

  rcfp_pack u_pack (
    .st           (st_r),
    .pos          (val_r),
    .dest_address (dest_r),
    .frame_type   (type_r),
    .type_crc     (type_crc_r),
    .burst        (burst),
    .st_nxt       (st_nxt)
  );

  // Packing state advances as each channel enters the burst register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s2_adv) begin
      st_r <= st_nxt;
    end
  end

  // Burst register; step through its bytes as they are taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r  <= 1'b0;
      idx_r <= 2'd0;
    end else if (s2_adv) begin
      bv_r  <= 1'b1;
      idx_r <= 2'd0;
    end else if (take_last) begin
      bv_r  <= 1'b0;
      idx_r <= 2'd0;
    end else if (bv_r && out_tready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      burst_r <= burst;
    end
  end

  // Output channel
  assign out_tvalid = bv_r;
  assign out_tdata  = burst_r.bytes[idx_r];
  assign out_tuser  = at_last;
  assign out_tlast  = burst_r.eof & at_last;

endmodule

### sim/tb_rc_channel_frame_packer.sv
`timescale 1ns / 100ps

module tb_rc_channel_frame_packer;
  import rcfp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 90;

  // One byte of the outgoing frame with its markers
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eof;
  } frame_byte_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // channel_value[15:0]
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // frame_byte[7:0]
  logic [7:0]  out_tdata;
  logic        out_tlast;
  // last_of_item[0]
  logic        out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Packing state mirrored from the block
  int          ch_pos = 0;
  logic [17:0] acc_bits = '0;
  int          acc_count = 0;
  logic [7:0]  crc_run = '0;
  logic [7:0]  cfg_dest = DEST_RESET;
  logic [7:0]  cfg_type = TYPE_RESET;

  frame_byte_t expected_bytes[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  logic        tx_idle_on = 1'b1;
  logic        rx_idle_on = 1'b1;
  logic        rx_hold_req = 1'b0;
  int          hold_left = 0;
  int          rx_wait = 0;

  rc_channel_frame_packer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // CRC8 folded one bit at a time, MSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[7] ^ b[k];
      r = {r[6:0], 1'b0};
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  // Work out the bytes one channel value causes and queue them
  function automatic void predict_channel(input logic [15:0] raw);
    int          value;
    int          pos;
    logic [31:0] shifted;
    frame_byte_t tail;
    value = int'($signed(raw));
    pos = int'(CH_CENTER) + (value * 4) / 5;
    if (pos < 0) pos = 0;
    if (pos > 2 * int'(CH_CENTER)) pos = 2 * int'(CH_CENTER);

    // Frame header ahead of the first channel
    if (ch_pos == 0) begin
      acc_bits = '0;
      acc_count = 0;
      expected_bytes.push_back('{data: cfg_dest, last: 1'b0, eof: 1'b0});
      expected_bytes.push_back('{data: FRAME_LEN, last: 1'b0, eof: 1'b0});
      expected_bytes.push_back('{data: cfg_type, last: 1'b0, eof: 1'b0});
      crc_run = crc8_step(8'h00, cfg_type);
    end

    // Pack 11 bits LSB first and drain whole bytes
    shifted = 32'(pos) << (acc_count & 7);
    acc_bits = acc_bits | shifted[17:0];
    acc_count = (acc_count & 7) + int'(CH_BITS);
    while (acc_count >= 8) begin
      expected_bytes.push_back('{data: acc_bits[7:0], last: 1'b0, eof: 1'b0});
      crc_run = crc8_step(crc_run, acc_bits[7:0]);
      acc_bits = acc_bits >> 8;
      acc_count -= 8;
    end

    // Close the frame with the CRC
    if (ch_pos == int'(CH_COUNT) - 1) begin
      expected_bytes.push_back('{data: crc_run, last: 1'b0, eof: 1'b1});
      ch_pos = 0;
      acc_bits = '0;
      acc_count = 0;
    end else begin
      ch_pos++;
    end

    tail = expected_bytes.pop_back();
    tail.last = 1'b1;
    expected_bytes.push_back(tail);
  endfunction

  // Check each accepted byte and pace out_tready
  always @(posedge clk) begin : rx_side
    frame_byte_t want;
    logic        bad;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte, expected none, got %02h last %0b eof %0b",
                   $time, out_tdata, out_tuser, out_tlast);
          mismatch_count++;
        end else begin
          want = expected_bytes.pop_front();
          bad = 1'b0;
          if (out_tdata !== want.data) begin
            $display("%0t: frame_byte expected %02h, got %02h", $time, want.data, out_tdata);
            bad = 1'b1;
          end
          if (out_tuser !== want.last) begin
            $display("%0t: last_of_item expected %0b, got %0b", $time, want.last, out_tuser);
            bad = 1'b1;
          end
          if (out_tlast !== want.eof) begin
            $display("%0t: end_of_frame expected %0b, got %0b", $time, want.eof, out_tlast);
            bad = 1'b1;
          end
          if (bad) mismatch_count++;
        end
        rx_wait = rx_idle_on ? int'($urandom_range(0, 11)) : 0;
      end
      if (rx_hold_req) begin
        hold_left = HOLD_CYCLES;
        rx_hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one channel value and hold it until accepted
  task automatic send_channel(input logic [15:0] value);
    int gap;
    gap = tx_idle_on ? int'($urandom_range(0, 11)) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    predict_channel(value);
  endtask

  // Drop valid and wait until every queued byte has come out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_bytes.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write: setup then access
  task automatic cfg_write(input logic reg_sel, input logic [7:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= {24'h0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (reg_sel == REG_DEST) cfg_dest = value;
    else cfg_type = value;
    @(posedge clk);
  endtask

  // Mostly nominal positions, some full range, some around the clamp points
  function automatic logic [15:0] random_channel();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = int'($urandom_range(0, 2048)) - 1024;
      6:                v = int'($urandom_range(0, 65535));
      7:                v = int'($urandom_range(1234, 1248));
      8:                v = -int'($urandom_range(1234, 1248));
      default:          v = int'($urandom_range(0, 12)) - 6;
    endcase
    return 16'(v);
  endfunction

  // One frame of extremes and rounding cases under the reset register values
  task automatic test_channel_extremes();
    logic [15:0] vals[16];
    vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h0002,
             16'd1240, 16'd1241, 16'd1242, -16'sd1240, -16'sd1241, -16'sd1242,
             16'd1024, -16'sd1024, -16'sd5};
    foreach (vals[i]) send_channel(vals[i]);
    wait_idle();
  endtask

  // Register extremes, including a write in the middle of a frame
  task automatic test_register_extremes();
    cfg_write(REG_DEST, 8'h00);
    cfg_write(REG_TYPE, 8'hFF);
    repeat (16) send_channel(random_channel());
    repeat (7) send_channel(random_channel());
    wait_idle();
    // new values apply only from the next frame
    cfg_write(REG_DEST, 8'hFF);
    cfg_write(REG_TYPE, 8'h00);
    repeat (9) send_channel(random_channel());
    repeat (9) send_channel(random_channel());
    wait_idle();
  endtask

  // Hold the output off while values keep coming, so the input stalls
  task automatic test_input_backpressure();
    tx_idle_on = 1'b0;
    rx_hold_req <= 1'b1;
    repeat (24) send_channel(random_channel());
    wait_idle();
    tx_idle_on = 1'b1;
  endtask

  // Random values, random pacing, occasional register changes
  task automatic test_random_traffic();
    for (int n = 0; n < 145; n++) begin
      if (ch_pos == 0) begin
        tx_idle_on = ($urandom_range(0, 2) != 0);
        rx_idle_on <= ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 19) == 0) begin
        wait_idle();
        if ($urandom_range(0, 1) == 0) cfg_write(REG_DEST, 8'($urandom_range(0, 255)));
        else cfg_write(REG_TYPE, 8'($urandom_range(0, 255)));
      end
      send_channel(random_channel());
    end
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_channel_extremes();
    test_register_extremes();
    test_input_backpressure();
    test_random_traffic();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/rcfp_pkg.sv
rtl/core/rcfp_scale.sv
rtl/core/rcfp_pack.sv
rtl/core/rc_channel_frame_packer.sv
sim/tb_rc_channel_frame_packer.sv
